/* rtl/branch_and_condition_register_unit_top_defines.svh */
// Assertion macros for the branch and condition register unit.
// Used by bcru_exec, which checks its own logic; relies on clk and rst_n in scope.
`ifndef BRANCH_AND_CONDITION_REGISTER_UNIT_TOP_DEFINES_SVH
`define BRANCH_AND_CONDITION_REGISTER_UNIT_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define BCRU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BCRU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bcru_pkg.sv */
// Shared types and constants for the branch and condition register unit.
// No dependencies; imported by every module of the block.
package bcru_pkg;

    typedef enum logic [3:0] {
        OP_B        = 4'd0,
        OP_BC       = 4'd1,
        OP_BCCTR    = 4'd2,
        OP_BCLR     = 4'd3,
        OP_CRAND    = 4'd4,
        OP_CRANDC   = 4'd5,
        OP_CREQV    = 4'd6,
        OP_CRNAND   = 4'd7,
        OP_CRNOR    = 4'd8,
        OP_CROR     = 4'd9,
        OP_CRORC    = 4'd10,
        OP_CRXOR    = 4'd11,
        OP_MCRF     = 4'd12,
        OP_LOAD_CTR = 4'd13,
        OP_LOAD_LR  = 4'd14,
        OP_LOAD_CR  = 4'd15
    } op_t;

    // Bit positions inside the bo field
    localparam int unsigned BO_NO_COND = 4;
    localparam int unsigned BO_SENSE   = 3;
    localparam int unsigned BO_NO_DEC  = 2;
    localparam int unsigned BO_ZERO    = 1;

    localparam logic [63:0] ALIGN_MASK = ~64'h3;
    localparam logic [63:0] INSTR_SIZE = 64'd4;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [63:0]        address;
        logic [4:0]         bo;
        logic [4:0]         condition_bit;
        logic               absolute;
        logic               link;
        logic signed [23:0] displacement;
        logic [4:0]         src_a;
        logic [4:0]         src_b;
        logic [4:0]         dest;
        logic [63:0]        load_value;
    } instr_t;

    typedef struct packed {
        logic [63:0] next_address;
        logic        taken;
        logic [63:0] link_value;
        logic [63:0] count_value;
        logic [31:0] condition_value;
    } result_t;

    // Handshake between the instruction register and the execute/result side
    typedef struct packed {
        logic valid;
        logic fire;
    } stage_ctl_t;

endpackage

/* rtl/bcru_instr_if.sv */
// Instruction channel: valid/ready handshake with the instruction fields.
// No dependencies; the field widths mirror those of bcru_pkg.
interface bcru_instr_if;
    logic               valid;
    logic               ready;
    logic [3:0]         opcode;
    logic [63:0]        address;
    logic [4:0]         bo;
    logic [4:0]         condition_bit;
    logic               absolute;
    logic               link;
    logic signed [23:0] displacement;
    logic [4:0]         src_a;
    logic [4:0]         src_b;
    logic [4:0]         dest;
    logic [63:0]        load_value;

    modport source (
        output valid, opcode, address, bo, condition_bit, absolute, link,
               displacement, src_a, src_b, dest, load_value,
        input  ready
    );

    modport sink (
        input  valid, opcode, address, bo, condition_bit, absolute, link,
               displacement, src_a, src_b, dest, load_value,
        output ready
    );
endinterface

/* rtl/bcru_result_if.sv */
// Result channel: valid/ready handshake with the result fields.
// No dependencies; the field widths mirror those of bcru_pkg.
interface bcru_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] next_address;
    logic        taken;
    logic [63:0] link_value;
    logic [63:0] count_value;
    logic [31:0] condition_value;

    modport source (
        output valid, next_address, taken, link_value, count_value, condition_value,
        input  ready
    );

    modport sink (
        input  valid, next_address, taken, link_value, count_value, condition_value,
        output ready
    );
endinterface

/* rtl/branch_and_condition_register_unit_top.sv */
// Branch and condition register unit: b, bc, bcctr, bclr, CR logic, mcrf, loads.
// The accepting edge loads the instruction register; the item moves on into the result
// register, updating CR, LR and CTR, once that register is free.
// Throughput: one item per cycle while the result channel is ready.
// Reset: rst_n clears both stage valids and the condition, link and count registers.
module branch_and_condition_register_unit_top
    import bcru_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    bcru_instr_if.sink    instr,
    bcru_result_if.source result
);

    stage_ctl_t ctl;
    instr_t     item;
    result_t    res;
    logic       out_free;

    bcru_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .instr    (instr),
        .out_free (out_free),
        .ctl      (ctl),
        .item     (item)
    );

    bcru_exec u_exec (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .item  (item),
        .res   (res)
    );

    bcru_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .res      (res),
        .out_free (out_free),
        .result   (result)
    );

endmodule

/* rtl/bcru_in_stage.sv */
// Instruction register: captures one item from the instruction channel.
// Depends on bcru_pkg and bcru_instr_if.
module bcru_in_stage
    import bcru_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bcru_instr_if.sink   instr,
    input  logic         out_free,
    output stage_ctl_t   ctl,
    output instr_t       item
);

    logic   valid_reg;
    logic   valid_next;
    instr_t item_reg;
    logic   fire;
    logic   accept;

    // The held item executes as soon as the result register can take it
    assign fire        = valid_reg && out_free;
    assign instr.ready = !valid_reg || fire;
    assign accept      = instr.valid && instr.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode        <= instr.opcode;
            item_reg.address       <= instr.address;
            item_reg.bo            <= instr.bo;
            item_reg.condition_bit <= instr.condition_bit;
            item_reg.absolute      <= instr.absolute;
            item_reg.link          <= instr.link;
            item_reg.displacement  <= instr.displacement;
            item_reg.src_a         <= instr.src_a;
            item_reg.src_b         <= instr.src_b;
            item_reg.dest          <= instr.dest;
            item_reg.load_value    <= instr.load_value;
        end
    end

    assign ctl.valid = valid_reg;
    assign ctl.fire  = fire;
    assign item      = item_reg;

endmodule

/* rtl/bcru_exec.sv */
// Execute logic and architectural registers (condition, link, count).
// Depends on bcru_pkg and the assertion macros header.
module bcru_exec
    import bcru_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  stage_ctl_t ctl,
    input  instr_t     item,
    output result_t    res
);

    logic [31:0] cr_reg;
    logic [31:0] cr_next;
    logic [63:0] link_reg;
    logic [63:0] link_next;
    logic [63:0] count_reg;
    logic [63:0] count_next;

    op_t         op;
    logic        is_branch;
    logic [63:0] seq_addr;
    logic [63:0] off24;
    logic [63:0] off14;
    logic [63:0] offset;
    logic [63:0] target;
    logic [63:0] count_after;
    logic        cond_ok;
    logic        count_ok;
    logic        bit_x;
    logic        bit_y;
    logic        bit_v;
    logic [3:0]  field_val;
    logic [31:0] cr_mcrf;
    logic [31:0] cr_bitop;
    logic [63:0] next_addr;
    logic        taken;

    assign op        = op_t'(item.opcode);
    assign is_branch = op inside {OP_B, OP_BC, OP_BCCTR, OP_BCLR};
    assign seq_addr  = item.address + INSTR_SIZE;
    assign off24     = {{38{item.displacement[23]}}, item.displacement, 2'b00};
    assign off14     = {{48{item.displacement[13]}}, item.displacement[13:0], 2'b00};
    assign offset    = (op == OP_B) ? off24 : off14;
    assign target    = item.absolute ? offset : item.address + offset;

    // bc and bclr test the count after the decrement
    assign count_after = item.bo[BO_NO_DEC] ? count_reg : count_reg - 64'd1;
    assign count_ok    = item.bo[BO_NO_DEC]
                         || ((count_after != 64'd0) != item.bo[BO_ZERO]);
    // Condition bit 0 is the msb of the register
    assign cond_ok     = item.bo[BO_NO_COND]
                         || (cr_reg[~item.condition_bit] == item.bo[BO_SENSE]);

    assign bit_x = cr_reg[~item.src_a];
    assign bit_y = cr_reg[~item.src_b];

    always_comb
    begin
        case (op)
            OP_CRAND:  bit_v = bit_x & bit_y;
            OP_CRANDC: bit_v = bit_x & ~bit_y;
            OP_CREQV:  bit_v = ~(bit_x ^ bit_y);
            OP_CRNAND: bit_v = ~(bit_x & bit_y);
            OP_CRNOR:  bit_v = ~(bit_x | bit_y);
            OP_CROR:   bit_v = bit_x | bit_y;
            OP_CRORC:  bit_v = bit_x | ~bit_y;
            default:   bit_v = bit_x ^ bit_y;
        endcase
    end

    always_comb
    begin
        cr_bitop                 = cr_reg;
        cr_bitop[~item.dest]     = bit_v;
        field_val                = cr_reg[{~item.src_a[2:0], 2'b00} +: 4];
        cr_mcrf                  = cr_reg;
        cr_mcrf[{~item.dest[2:0], 2'b00} +: 4] = field_val;
    end

    always_comb
    begin
        next_addr  = seq_addr;
        taken      = 1'b0;
        cr_next    = cr_reg;
        link_next  = link_reg;
        count_next = count_reg;
        case (op)
            OP_B:
            begin
                next_addr = target & ALIGN_MASK;
                taken     = 1'b1;
                if (item.link)
                begin
                    link_next = seq_addr;
                end
            end
            OP_BC:
            begin
                count_next = count_after;
                if (count_ok && cond_ok)
                begin
                    next_addr = target & ALIGN_MASK;
                    taken     = 1'b1;
                end
                if (item.link)
                begin
                    link_next = seq_addr;
                end
            end
            OP_BCCTR:
            begin
                if (cond_ok)
                begin
                    next_addr = count_reg & ALIGN_MASK;
                    taken     = 1'b1;
                end
                if (item.link)
                begin
                    link_next = seq_addr;
                end
            end
            OP_BCLR:
            begin
                count_next = count_after;
                // Target comes from the link register before this item writes it
                if (count_ok && cond_ok)
                begin
                    next_addr = link_reg & ALIGN_MASK;
                    taken     = 1'b1;
                end
                if (item.link)
                begin
                    link_next = seq_addr;
                end
            end
            OP_MCRF:     cr_next    = cr_mcrf;
            OP_LOAD_CTR: count_next = item.load_value;
            OP_LOAD_LR:  link_next  = item.load_value;
            OP_LOAD_CR:  cr_next    = item.load_value[31:0];
            default:     cr_next    = cr_bitop;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_reg    <= 32'd0;
            link_reg  <= 64'd0;
            count_reg <= 64'd0;
        end
        else if (ctl.fire)
        begin
            cr_reg    <= cr_next;
            link_reg  <= link_next;
            count_reg <= count_next;
        end
    end

    assign res.next_address    = next_addr;
    assign res.taken           = taken;
    assign res.link_value      = link_next;
    assign res.count_value     = count_next;
    assign res.condition_value = cr_next;

`include "branch_and_condition_register_unit_top_defines.svh"

    `BCRU_ASSERT_NOW(a_taken_only_branch, ctl.fire && !is_branch, !res.taken, "taken on non-branch item")
    `BCRU_ASSERT_NOW(a_target_aligned, ctl.fire && res.taken, res.next_address[1:0] == 2'b00, "unaligned target")
    `BCRU_ASSERT_NEXT(a_idle_holds_state, !ctl.fire, $stable(cr_reg) && $stable(link_reg) && $stable(count_reg), "state moved without an item")
    `BCRU_ASSERT_NEXT(a_count_owner, ctl.fire && !(op == OP_BC || op == OP_BCLR || op == OP_LOAD_CTR), count_reg == $past(count_reg), "count changed by wrong opcode")
    `BCRU_ASSERT_NOW(a_fire_needs_valid, ctl.fire, ctl.valid, "execute without a held item")

endmodule

/* rtl/bcru_out_stage.sv */
// Result register: holds one finished item until the result channel takes it.
// Depends on bcru_pkg and bcru_result_if.
module bcru_out_stage
    import bcru_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  stage_ctl_t    ctl,
    input  result_t       res,
    output logic          out_free,
    bcru_result_if.source result
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Free when empty or when the held item leaves this cycle
    assign out_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.fire)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            res_reg <= res;
        end
    end

    assign result.valid           = valid_reg;
    assign result.next_address    = res_reg.next_address;
    assign result.taken           = res_reg.taken;
    assign result.link_value      = res_reg.link_value;
    assign result.count_value     = res_reg.count_value;
    assign result.condition_value = res_reg.condition_value;

endmodule
